FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: src/msbpk_pkg.sv
package msbpk_pkg;

  localparam int ADDR_WIDTH_DEF = 12;
  localparam int IN_ADDR_W      = 12;
  localparam int BYTE_W         = 8;
  localparam int TOTAL_W        = 32;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_PUT   = 3'd1,
    CMD_GET   = 3'd2,
    CMD_SEEK  = 3'd3,
    CMD_LOAD  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT0,
    S_PUT1,
    S_GET0,
    S_GET1
  } state_t;

  function automatic logic [7:0] get_field(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [2:0] off, input logic [3:0] n);
    logic [15:0] win;
    logic [7:0]  mask;
    win  = {b0, b1} << off;
    mask = ~(8'hFF >> n);
    return win[15:8] & mask;
  endfunction

endpackage

FILE: src/msbpk_ram.sv
module msbpk_ram #(
  parameter int WIDTH = msbpk_pkg::BYTE_W,
  parameter int DEPTH = 1 << msbpk_pkg::ADDR_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/msb_first_bit_packer_unpacker.sv
// MSB-first bit stream writer and reader over a single-port byte store of
// 2^ADDR_WIDTH bytes. An item is taken when start is high and busy is low;
// its one result appears on out_read_bits and out_bit_total for a single
// cycle with out_valid high, and the receiver cannot stall it, so sample it
// on that cycle. Start, seek, load, unknown commands and put/get with a count
// outside 1..8 show their result in the cycle after they are taken. Put and
// get access the store's one port byte by byte, and its read is registered; a
// field that crosses a byte boundary, or a put that ends on one and advances,
// touches the next byte too. Busy stays high until the last access is done; a
// new item may be taken in the cycle its predecessor's result is shown. The
// store has no reset. The user must read it only where it was written before;
// the block itself does not enforce this.
`include "assert_macros.svh"

module msb_first_bit_packer_unpacker #(
  parameter int ADDR_WIDTH = msbpk_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            in_cmd,
  input  logic [msbpk_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic signed [15:0]                    in_bits,
  input  logic                                  in_no_advance,
  input  logic [msbpk_pkg::IN_ADDR_W-1:0]       in_address,
  output logic                                  out_valid,
  output logic [msbpk_pkg::BYTE_W-1:0]          out_read_bits,
  output logic [msbpk_pkg::TOTAL_W-1:0]         out_bit_total
);

  localparam int PW = ADDR_WIDTH + 3;

  msbpk_pkg::state_t state_r, state_nxt;
  logic [ADDR_WIDTH-1:0] cursor_r, cursor_nxt;
  logic [2:0]            offset_r, offset_nxt;
  logic [31:0]           moved_r, moved_nxt;
  logic                  first_r, first_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_bits_r, out_bits_nxt;
  logic [31:0]           out_total_r, out_total_nxt;

  logic [ADDR_WIDTH-1:0] it_addr_r, it_addr_nxt;
  logic [2:0]            it_off_r, it_off_nxt;
  logic [3:0]            it_n_r, it_n_nxt;
  logic [7:0]            it_data_r, it_data_nxt;
  logic                  it_cross_r, it_cross_nxt;
  logic                  it_wr_next_r, it_wr_next_nxt;
  logic [7:0]            it_next_r, it_next_nxt;
  logic [7:0]            b0_r, b0_nxt;

  logic                  mem_we;
  logic [ADDR_WIDTH-1:0] mem_addr;
  logic [7:0]            mem_wdata;
  logic [7:0]            mem_rdata;

  logic                  n_valid;
  logic [3:0]            n_in;
  logic [3:0]            end_in;
  logic                  adv;
  logic                  cross_in;
  logic [15:0]           sh_in;
  logic [15:0]           it_sh;
  logic [PW-1:0]         disp;
  logic [PW-1:0]         pos;
  logic [ADDR_WIDTH-1:0] addr_in;
  logic [ADDR_WIDTH-1:0] it_addr_inc;
  logic                  accept;
  logic                  quick_cmd;
  logic                  get0_cross;

  assign accept      = start && (state_r == msbpk_pkg::S_IDLE);
  assign n_valid     = (in_bits >= 16'sd1) && (in_bits <= 16'sd8);
  assign n_in        = in_bits[3:0];
  assign end_in      = {1'b0, offset_r} + n_in;
  assign adv         = n_valid && !in_no_advance;
  assign cross_in    = end_in > 4'd8;
  assign sh_in       = {in_data_byte, 8'h00} >> offset_r;
  assign it_sh       = {it_data_r, 8'h00} >> it_off_r;
  assign disp        = PW'(in_bits);
  assign pos         = {cursor_r, offset_r} + disp;
  assign addr_in     = ADDR_WIDTH'(in_address);
  assign it_addr_inc = it_addr_r + ADDR_WIDTH'(1);
  assign quick_cmd   = in_cmd inside {msbpk_pkg::CMD_START, msbpk_pkg::CMD_SEEK,
                                      msbpk_pkg::CMD_LOAD};
  assign get0_cross  = (state_r == msbpk_pkg::S_GET0) && it_cross_r;

  msbpk_ram #(
    .WIDTH (msbpk_pkg::BYTE_W),
    .DEPTH (1 << ADDR_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    offset_nxt     = offset_r;
    moved_nxt      = moved_r;
    first_nxt      = first_r;
    out_valid_nxt  = 1'b0;
    out_bits_nxt   = out_bits_r;
    it_addr_nxt    = it_addr_r;
    it_off_nxt     = it_off_r;
    it_n_nxt       = it_n_r;
    it_data_nxt    = it_data_r;
    it_cross_nxt   = it_cross_r;
    it_wr_next_nxt = it_wr_next_r;
    it_next_nxt    = it_next_r;
    b0_nxt         = b0_r;
    mem_we         = 1'b0;
    mem_addr       = it_addr_r;
    mem_wdata      = 8'h00;

    case (state_r)
      msbpk_pkg::S_IDLE: begin
        if (start) begin
          it_addr_nxt    = cursor_r;
          it_off_nxt     = offset_r;
          it_n_nxt       = n_in;
          it_data_nxt    = in_data_byte;
          it_cross_nxt   = cross_in;
          it_wr_next_nxt = cross_in || ((end_in == 4'd8) && !in_no_advance);
          it_next_nxt    = cross_in ? sh_in[7:0] : 8'h00;
          out_bits_nxt   = 8'h00;
          case (in_cmd)
            msbpk_pkg::CMD_START: begin
              cursor_nxt    = addr_in;
              offset_nxt    = 3'd0;
              moved_nxt     = 32'd0;
              first_nxt     = 1'b1;
              out_valid_nxt = 1'b1;
            end
            msbpk_pkg::CMD_PUT: begin
              first_nxt = 1'b0;
              mem_addr  = cursor_r;
              if (!n_valid) begin
                mem_we        = first_r;
                out_valid_nxt = 1'b1;
              end else begin
                if (adv) begin
                  cursor_nxt = cursor_r + ADDR_WIDTH'(end_in[3]);
                  offset_nxt = end_in[2:0];
                  moved_nxt  = moved_r + 32'(n_in);
                end
                if (first_r) begin
                  mem_we    = 1'b1;
                  mem_wdata = sh_in[15:8];
                  if (cross_in || ((end_in == 4'd8) && !in_no_advance)) begin
                    state_nxt = msbpk_pkg::S_PUT1;
                  end else begin
                    out_valid_nxt = 1'b1;
                  end
                end else begin
                  state_nxt = msbpk_pkg::S_PUT0;
                end
              end
            end
            msbpk_pkg::CMD_GET: begin
              mem_addr = cursor_r;
              if (!n_valid) begin
                out_valid_nxt = 1'b1;
              end else begin
                if (adv) begin
                  cursor_nxt = cursor_r + ADDR_WIDTH'(end_in[3]);
                  offset_nxt = end_in[2:0];
                  moved_nxt  = moved_r + 32'(n_in);
                end
                state_nxt = msbpk_pkg::S_GET0;
              end
            end
            msbpk_pkg::CMD_SEEK: begin
              cursor_nxt    = pos[PW-1:3];
              offset_nxt    = pos[2:0];
              out_valid_nxt = 1'b1;
            end
            msbpk_pkg::CMD_LOAD: begin
              mem_we        = 1'b1;
              mem_addr      = addr_in;
              mem_wdata     = in_data_byte;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      msbpk_pkg::S_PUT0: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | it_sh[15:8];
        if (it_wr_next_r) begin
          state_nxt = msbpk_pkg::S_PUT1;
        end else begin
          state_nxt     = msbpk_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      msbpk_pkg::S_PUT1: begin
        mem_we        = 1'b1;
        mem_addr      = it_addr_inc;
        mem_wdata     = it_next_r;
        state_nxt     = msbpk_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
      end
      msbpk_pkg::S_GET0: begin
        b0_nxt = mem_rdata;
        if (it_cross_r) begin
          mem_addr  = it_addr_inc;
          state_nxt = msbpk_pkg::S_GET1;
        end else begin
          out_bits_nxt  = msbpk_pkg::get_field(mem_rdata, 8'h00, it_off_r, it_n_r);
          state_nxt     = msbpk_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      msbpk_pkg::S_GET1: begin
        out_bits_nxt  = msbpk_pkg::get_field(b0_r, mem_rdata, it_off_r, it_n_r);
        state_nxt     = msbpk_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = msbpk_pkg::S_IDLE;
      end
    endcase

    out_total_nxt = out_valid_nxt ? moved_nxt : out_total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msbpk_pkg::S_IDLE;
      cursor_r    <= '0;
      offset_r    <= 3'd0;
      moved_r     <= 32'd0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      offset_r    <= offset_nxt;
      moved_r     <= moved_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bits_r   <= out_bits_nxt;
    out_total_r  <= out_total_nxt;
    it_addr_r    <= it_addr_nxt;
    it_off_r     <= it_off_nxt;
    it_n_r       <= it_n_nxt;
    it_data_r    <= it_data_nxt;
    it_cross_r   <= it_cross_nxt;
    it_wr_next_r <= it_wr_next_nxt;
    it_next_r    <= it_next_nxt;
    b0_r         <= b0_nxt;
  end

  assign busy          = (state_r != msbpk_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_bits = out_bits_r;
  assign out_bit_total = out_total_r;

  `ASSERT_IMPL(a_strobe_when_idle, clk, rst_n, out_valid_r, state_r == msbpk_pkg::S_IDLE)
  `ASSERT_NEXT(a_quick_cmds, clk, rst_n, accept && quick_cmd, out_valid_r)
  `ASSERT_IMPL(a_next_write_needed, clk, rst_n, state_r == msbpk_pkg::S_PUT1, it_wr_next_r && mem_we)
  `ASSERT_NEXT(a_second_read_cross, clk, rst_n, get0_cross, state_r == msbpk_pkg::S_GET1)

endmodule

FILE: tb/msb_first_bit_packer_unpacker_tb.sv
`timescale 1ns / 100ps

module msb_first_bit_packer_unpacker_tb;
  import msbpk_pkg::*;

  localparam int AW = ADDR_WIDTH_DEF;
  localparam int DEPTH = 1 << AW;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_MID = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_bits;
    logic [TOTAL_W-1:0] bit_total;
  } word_t;

  class bit_cursor_model;
    logic [7:0]    mem [DEPTH];
    bit            written [DEPTH];
    logic [AW-1:0] cur_addr;
    logic [2:0]    bit_off;
    logic [31:0]   moved;
    bit            first_put;
    word_t         awaited [$];
    int            mismatches;
    int            checked;
    int            cmd_seen [8];

    function new();
      cur_addr = '0;
      bit_off = '0;
      moved = '0;
      first_put = 1'b1;
      mismatches = 0;
      checked = 0;
      foreach (written[i]) written[i] = 1'b0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    function bit count_ok(input logic signed [15:0] bits);
      return bits >= 1 && bits <= 8;
    endfunction

    // report a byte that the item would read before anything wrote it
    function bit unwritten_read(input logic [2:0] cmd, input logic signed [15:0] bits,
                                output logic [AW-1:0] addr);
      logic [AW-1:0] nxt;
      int unsigned   n;
      addr = cur_addr;
      nxt = cur_addr + 1'b1;
      if (!count_ok(bits)) return 1'b0;
      n = bits[3:0];
      if (cmd == CMD_PUT && !first_put && !written[cur_addr]) return 1'b1;
      if (cmd == CMD_GET) begin
        if (!written[cur_addr]) return 1'b1;
        if (bit_off + n > 8 && !written[nxt]) begin
          addr = nxt;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void advance_cursor(input int unsigned n, input bit clear_next);
      int unsigned fin;
      fin = bit_off + n;
      if (fin >= 8) begin
        cur_addr = cur_addr + 1'b1;
        if (fin == 8 && clear_next) begin
          mem[cur_addr] = 8'h00;
          written[cur_addr] = 1'b1;
        end
      end
      bit_off = fin[2:0];
      moved = moved + n;
    endfunction

    function void take_word(input logic [2:0] cmd, input logic [7:0] data,
                            input logic signed [15:0] bits, input logic noadv,
                            input logic [11:0] addr);
      logic [7:0]      rd;
      int unsigned     n, o, b0, b1, rv;
      logic [AW-1:0]   nxt;
      logic [AW+2:0]   pos;
      rd = 8'h00;
      nxt = cur_addr + 1'b1;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_START: begin
          cur_addr = AW'(addr);
          bit_off = '0;
          moved = '0;
          first_put = 1'b1;
        end
        CMD_PUT: begin
          if (first_put) begin
            mem[cur_addr] = 8'h00;
            written[cur_addr] = 1'b1;
            first_put = 1'b0;
          end
          if (count_ok(bits)) begin
            n = bits[3:0];
            o = bit_off;
            mem[cur_addr] = mem[cur_addr] | 8'(data >> o);
            if (o + n > 8) begin
              mem[nxt] = 8'(data << (8 - o));
              written[nxt] = 1'b1;
            end
            if (!noadv) advance_cursor(n, 1'b1);
          end
        end
        CMD_GET: begin
          if (count_ok(bits)) begin
            n = bits[3:0];
            o = bit_off;
            b0 = mem[cur_addr];
            if (o + n <= 8) begin
              rv = ((b0 & (255 >> o) & (255 << (8 - o - n))) << o) & 255;
            end else begin
              b1 = mem[nxt];
              rv = (((b0 & (255 >> o)) << o) + ((b1 & (255 << (16 - o - n))) >> (8 - o))) & 255;
            end
            rd = 8'(rv);
            if (!noadv) advance_cursor(n, 1'b0);
          end
        end
        CMD_SEEK: begin
          if (bits != 0) begin
            pos = {cur_addr, bit_off} + (AW+3)'(bits);
            cur_addr = pos[AW+2:3];
            bit_off = pos[2:0];
          end
        end
        CMD_LOAD: begin
          mem[AW'(addr)] = data;
          written[AW'(addr)] = 1'b1;
        end
        default: begin
        end
      endcase
      awaited.push_back('{rd, moved});
    endfunction

    function void check_word(input logic [7:0] rb, input logic [31:0] bt);
      word_t w;
      if (awaited.size() == 0) begin
        $error("unexpected word: read_bits %0h, bit_total %0h", rb, bt);
        mismatches++;
        return;
      end
      w = awaited.pop_front();
      checked++;
      if (rb !== w.read_bits) begin
        $error("read_bits: expected %0h, got %0h", w.read_bits, rb);
        mismatches++;
      end
      if (bt !== w.bit_total) begin
        $error("bit_total: expected %0h, got %0h", w.bit_total, bt);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [2:0]           in_cmd = CMD_START;
  logic [BYTE_W-1:0]    in_data_byte = '0;
  logic signed [15:0]   in_bits = '0;
  logic                 in_no_advance = 1'b0;
  logic [IN_ADDR_W-1:0] in_address = '0;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_read_bits;
  logic [TOTAL_W-1:0]   out_bit_total;

  bit_cursor_model model;
  int              sent = 0;
  int              idle_pct = 0;
  int              cycles = 0;

  msb_first_bit_packer_unpacker uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_data_byte  (in_data_byte),
    .in_bits       (in_bits),
    .in_no_advance (in_no_advance),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_read_bits (out_read_bits),
    .out_bit_total (out_bit_total)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) model.check_word(out_read_bits, out_bit_total);
  end

  task automatic issue(input logic [2:0] c, input logic [7:0] d, input logic signed [15:0] b,
                       input logic na, input logic [11:0] a);
    logic [AW-1:0] hole;
    int            gap;
    // load the missing byte instead of reading it unwritten
    if (model.unwritten_read(c, b, hole)) begin
      c = CMD_LOAD;
      a = 12'(hole);
      d = 8'($urandom);
    end
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_data_byte <= d;
    in_bits <= b;
    in_no_advance <= na;
    in_address <= a;
    do @(posedge clk); while (busy);
    model.take_word(c, d, b, na, a);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (model.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_base();
    if ($urandom_range(3) == 0) return 12'($urandom_range(4095 - 2, 4095));
    return 12'($urandom);
  endfunction

  task automatic write_read_run();
    logic [11:0] base;
    int          k, nput, nget;
    base = pick_base();
    nput = $urandom_range(1, 12);
    nget = $urandom_range(1, 14);
    issue(CMD_START, 8'($urandom), 16'($urandom), 1'($urandom), base);
    for (k = 0; k < nput; k++)
      issue(CMD_PUT, 8'($urandom), 16'($urandom_range(1, 8)), $urandom_range(7) == 0,
            12'($urandom));
    issue(CMD_START, 8'($urandom), 16'($urandom), 1'($urandom), base);
    for (k = 0; k < nget; k++) begin
      if ($urandom_range(5) == 0)
        issue(CMD_SEEK, 8'($urandom), 16'(int'($urandom_range(32)) - 16), 1'($urandom),
              12'($urandom));
      else
        issue(CMD_GET, 8'($urandom), 16'($urandom_range(1, 8)), $urandom_range(5) == 0,
              12'($urandom));
    end
  endtask

  task automatic load_read_run();
    logic [11:0] base;
    int          k, nload, nget;
    base = pick_base();
    nload = $urandom_range(1, 6);
    nget = $urandom_range(1, 8);
    for (k = 0; k < nload; k++)
      issue(CMD_LOAD, 8'($urandom), 16'($urandom), 1'($urandom), base + 12'(k));
    issue(CMD_START, 8'($urandom), 16'($urandom), 1'($urandom), base);
    for (k = 0; k < nget; k++)
      issue(CMD_GET, 8'($urandom), 16'($urandom_range(1, 8)), $urandom_range(3) == 0,
            12'($urandom));
  endtask

  task automatic noise_run();
    int k, nitem;
    nitem = $urandom_range(1, 5);
    for (k = 0; k < nitem; k++)
      issue(3'($urandom_range(7)), 8'($urandom),
            $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(12)) - 2),
            1'($urandom), 12'($urandom));
  endtask

  initial begin
    int phase, goal, pick;
    model = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(CMD_LOAD, 8'hA5, 16'sd0, 1'b0, 12'hFFF);
    issue(CMD_LOAD, 8'h3C, 16'sd0, 1'b1, 12'h000);
    issue(CMD_START, 8'h00, 16'sd0, 1'b0, 12'hFFF);
    issue(CMD_PUT, 8'hFF, 16'sd0, 1'b0, 12'h000);
    issue(CMD_GET, 8'h00, 16'sd4, 1'b0, 12'h000);
    issue(CMD_PUT, 8'hFF, 16'sd3, 1'b0, 12'h000);
    issue(CMD_PUT, 8'hA0, 16'sd6, 1'b1, 12'h000);
    issue(CMD_PUT, 8'h80, 16'sd1, 1'b0, 12'h000);
    issue(CMD_GET, 8'h00, 16'sd9, 1'b0, 12'h000);
    issue(CMD_SEEK, 8'h00, -16'sd8, 1'b0, 12'h000);
    issue(CMD_GET, 8'h00, 16'sd8, 1'b0, 12'h000);
    issue(CMD_GET, 8'h00, 16'sd8, 1'b1, 12'h000);
    issue(CMD_SEEK, 8'h00, 16'sd0, 1'b0, 12'h000);
    issue(CMD_SEEK, 8'h00, 16'sh7FFF, 1'b0, 12'h000);
    issue(CMD_SEEK, 8'h00, 16'sh8000, 1'b1, 12'hFFF);
    issue(CMD_RSVD_LO, 8'hFF, 16'sd3, 1'b1, 12'hFFF);
    issue(CMD_RSVD_MID, 8'h00, 16'sh8000, 1'b0, 12'h000);
    issue(CMD_RSVD_HI, 8'hFF, 16'sh7FFF, 1'b1, 12'hFFF);
    issue(CMD_START, 8'h00, 16'sd0, 1'b0, 12'h800);
    issue(CMD_PUT, 8'h55, 16'sd8, 1'b1, 12'h000);
    issue(CMD_PUT, 8'h80, 16'sd1, 1'b0, 12'h000);
    issue(CMD_GET, 8'h00, 16'sd1, 1'b1, 12'h000);
    issue(CMD_GET, 8'h00, -16'sd1, 1'b0, 12'h000);
    issue(CMD_PUT, 8'h00, 16'sh7FFF, 1'b0, 12'h000);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      goal = sent + 100;
      while (sent < goal) begin
        if (phase == 3) begin
          case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 56;
            default: idle_pct = 16;
          endcase
        end else begin
          idle_pct = (phase == 0) ? 0 : (phase == 1) ? 56 : 16;
        end
        pick = $urandom_range(9);
        if (pick < 6) write_read_run();
        else if (pick < 8) load_read_run();
        else noise_run();
      end
      // hold off until every word is back
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Issued %0d commands: start %0d, put %0d, get %0d, seek %0d, load %0d, other %0d",
             sent, model.cmd_seen[CMD_START], model.cmd_seen[CMD_PUT], model.cmd_seen[CMD_GET],
             model.cmd_seen[CMD_SEEK], model.cmd_seen[CMD_LOAD],
             model.cmd_seen[CMD_RSVD_LO] + model.cmd_seen[CMD_RSVD_MID] +
             model.cmd_seen[CMD_RSVD_HI]);
    $display("Checked %0d words over four sender idle mixes, %0d mismatches",
             model.checked, model.mismatches);
    if (model.mismatches == 0 && model.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
